/* design/bvc_pkg.sv */
// Package for the blocked volume LRU cache: widths, codes, control types.
`timescale 1ns / 1ps
package bvc_pkg;

	localparam int COORD_BITS  = 10;
	localparam int NUM_DIMS    = 5;
	localparam int OFF_W       = 6;
	localparam int BN_OUT_W    = 12;
	localparam int FRAME_OUT_W = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int DIMS_W      = 3;
	localparam int EDGE_W      = 7;
	localparam int LIMIT_W     = 7;
	localparam int RADIX_W     = 11;
	localparam int MAX_EDGE    = 64;
	localparam int DEFAULT_EDGE = 8;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 3'd3;

	typedef logic [COORD_BITS-1:0] crd_t;
	typedef logic [OFF_W-1:0] off_t;

	typedef enum logic [1:0] {
		K_HIT_NEW,
		K_HIT,
		K_FILL,
		K_EVICT
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_DIVQ,
		S_MUL,
		S_MOD,
		S_MAPRD,
		S_OWNRD,
		S_DECIDE,
		S_VIC,
		S_LNKRD,
		S_UNLINK,
		S_PUSH1,
		S_PUSH2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic flush;
		logic div_coord;
		logic off_wr;
		logic mul;
		logic mod_wr;
		logic dim_next;
		logic map_rd;
		logic own_rd;
		logic decide;
		logic vic;
		logic lnk_rd;
		logic unlink;
		logic push1;
		logic push2;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  is_flush;
		logic  div_done;
		logic  last_dim;
		kind_t kind;
		logic  out_busy;
	} sts_t;

endpackage

/* design/bvc_if.sv */
// Handshake interfaces for access items, result items and configuration writes.
`timescale 1ns / 1ps
interface bvc_acc_if;
	import bvc_pkg::*;
	logic valid;
	logic ready;
	logic op;
	crd_t coord_x;
	crd_t coord_y;
	crd_t coord_z;
	crd_t coord_t;
	crd_t coord_v;
	modport source (output valid, op, coord_x, coord_y, coord_z, coord_t, coord_v,
		input ready);
	modport sink (input valid, op, coord_x, coord_y, coord_z, coord_t, coord_v,
		output ready);
endinterface

interface bvc_res_if;
	import bvc_pkg::*;
	logic valid;
	logic ready;
	logic hit;
	logic [BN_OUT_W-1:0] block_number;
	logic [FRAME_OUT_W-1:0] frame;
	logic evicted;
	logic [BN_OUT_W-1:0] victim_block;
	off_t offset_x;
	off_t offset_y;
	off_t offset_z;
	off_t offset_t;
	off_t offset_v;
	modport source (output valid, hit, block_number, frame, evicted, victim_block,
		offset_x, offset_y, offset_z, offset_t, offset_v, input ready);
	modport sink (input valid, hit, block_number, frame, evicted, victim_block,
		offset_x, offset_y, offset_z, offset_t, offset_v, output ready);
endinterface

interface bvc_cfg_if;
	import bvc_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/bvc_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bvc_div #(
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic          done
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] rem_sh;
	logic          ge;

	assign rem_sh = {rem_q[DW-2:0], quo_q[DW-1]};
	assign ge     = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sh - den_q : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

/* design/bvc_dp.sv */
// Datapath: config registers, block numbering, map, owner and recency memories.
`timescale 1ns / 1ps
module bvc_dp #(
	parameter int MAX_FRAMES    = 64,
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bvc_pkg::cmd_t cmd,
	output bvc_pkg::sts_t sts,
	bvc_acc_if.sink       acc,
	bvc_res_if.source     res,
	bvc_cfg_if.sink       cfg
);
	import bvc_pkg::*;

	localparam int TW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int LKW = $clog2(MAX_FRAMES + 1);
	localparam int FU  = LKW;
	localparam int LW  = 11;
	localparam logic [LKW-1:0] NONE = LKW'(MAX_FRAMES);

	// configuration
	logic [DIMS_W-1:0]  dims_q;
	logic [EDGE_W-1:0]  edge_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [RADIX_W-1:0] radix_q [NUM_DIMS];

	logic [DIMS_W-1:0]  nd_eff;
	logic [EDGE_W-1:0]  edge_eff;
	logic [LW-1:0]      limit_eff;
	logic [RADIX_W-1:0] radix_eff;

	// item state
	logic              op_q;
	crd_t              coord_q [NUM_DIMS];
	off_t              off_q [NUM_DIMS];
	logic [2:0]        d_q;
	crd_t              q_q;
	logic [TW-1:0]     prod_q;
	logic [TW-1:0]     bn_q;
	logic [TW-1:0]     clr_q;
	logic [FW-1:0]     f_q;
	logic              hit_q, ev_q;
	logic [TW-1:0]     vic_q;
	kind_t             kind_q;

	// recency state
	logic [FU-1:0]     fused_q;
	logic [LKW-1:0]    newest_q, oldest_q;

	// memories
	logic [FW-1:0]     map_mem [TABLE_ENTRIES];
	logic [TW-1:0]     own_mem [MAX_FRAMES];
	logic [LKW-1:0]    older_mem [MAX_FRAMES];
	logic [LKW-1:0]    newer_mem [MAX_FRAMES];
	logic [FW-1:0]     map_dout_q;
	logic [TW-1:0]     own_dout_q;
	logic [LKW-1:0]    old_dout_q, new_dout_q;

	// divider
	logic [COORD_BITS-1:0] div_num, div_den, div_quo, div_rem;
	logic                  div_done;

	// output register
	logic              out_valid_q;

	always_comb begin
		if (dims_q == '0) nd_eff = DIMS_W'(1);
		else if (dims_q > DIMS_W'(NUM_DIMS)) nd_eff = DIMS_W'(NUM_DIMS);
		else nd_eff = dims_q;
		if (edge_q == '0) edge_eff = EDGE_W'(1);
		else if (edge_q > EDGE_W'(MAX_EDGE)) edge_eff = EDGE_W'(MAX_EDGE);
		else edge_eff = edge_q;
		if (limit_q == '0) limit_eff = LW'(1);
		else if (LW'(limit_q) > LW'(MAX_FRAMES)) limit_eff = LW'(MAX_FRAMES);
		else limit_eff = LW'(limit_q);
		radix_eff = (radix_q[d_q] == '0) ? RADIX_W'(1) : radix_q[d_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= DIMS_W'(3);
			edge_q  <= EDGE_W'(DEFAULT_EDGE);
			limit_q <= LIMIT_W'(64);
			for (int i = 0; i < NUM_DIMS; i++) radix_q[i] <= RADIX_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DIMS:  dims_q  <= cfg.data[DIMS_W-1:0];
				REG_EDGE:  edge_q  <= cfg.data[EDGE_W-1:0];
				REG_LIMIT: limit_q <= cfg.data[LIMIT_W-1:0];
				default: begin
					if (cfg.index >= REG_BLOCKS)
						radix_q[cfg.index - REG_BLOCKS] <= cfg.data;
				end
			endcase
		end
	end
	assign cfg.ready = 1'b1;

	// divider splits the coordinate by the block edge
	assign div_num = coord_q[d_q];
	assign div_den = COORD_BITS'(edge_eff);

	bvc_div #(.DW(COORD_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_coord),
		.num   (div_num),
		.den   (div_den),
		.quo   (div_quo),
		.rem   (div_rem),
		.done  (div_done)
	);

	// lookup decision
	logic  hit_c;
	kind_t kind_c;
	always_comb begin
		hit_c = (FU'(map_dout_q) < fused_q) && (own_dout_q == bn_q);
		if (hit_c) kind_c = (LKW'(map_dout_q) == newest_q) ? K_HIT_NEW : K_HIT;
		else if (LW'(fused_q) < limit_eff) kind_c = K_FILL;
		else kind_c = K_EVICT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			d_q      <= '0;
			fused_q  <= '0;
			newest_q <= NONE;
			oldest_q <= NONE;
		end else begin
			if (cmd.clr) clr_q <= clr_q + TW'(1);
			if (cmd.load) d_q <= '0;
			else if (cmd.dim_next) d_q <= d_q + 3'd1;
			if (cmd.flush) begin
				fused_q  <= '0;
				newest_q <= NONE;
				oldest_q <= NONE;
			end
			if (cmd.decide && kind_c == K_FILL) fused_q <= fused_q + FU'(1);
			if (cmd.unlink) begin
				if (new_dout_q == NONE) newest_q <= old_dout_q;
				if (old_dout_q == NONE) oldest_q <= new_dout_q;
			end
			if (cmd.push1 && newest_q == NONE) oldest_q <= LKW'(f_q);
			if (cmd.push2) newest_q <= LKW'(f_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= acc.op;
			coord_q[0] <= acc.coord_x;
			coord_q[1] <= acc.coord_y;
			coord_q[2] <= acc.coord_z;
			coord_q[3] <= acc.coord_t;
			coord_q[4] <= acc.coord_v;
			off_q[0]   <= acc.coord_x[OFF_W-1:0];
			off_q[1]   <= acc.coord_y[OFF_W-1:0];
			off_q[2]   <= acc.coord_z[OFF_W-1:0];
			off_q[3]   <= acc.coord_t[OFF_W-1:0];
			off_q[4]   <= acc.coord_v[OFF_W-1:0];
			bn_q       <= '0;
			f_q        <= '0;
			hit_q      <= 1'b0;
			ev_q       <= 1'b0;
			vic_q      <= '0;
		end
		if (cmd.flush) begin
			for (int i = 0; i < NUM_DIMS; i++) off_q[i] <= '0;
		end
		if (cmd.off_wr) begin
			off_q[d_q] <= div_rem[OFF_W-1:0];
			q_q        <= div_quo;
		end
		// table size is a power of two: the wrap is the low TW bits
		if (cmd.mul) prod_q <= bn_q * TW'(radix_eff) + TW'(q_q);
		if (cmd.mod_wr) bn_q <= prod_q;
		if (cmd.decide) begin
			kind_q <= kind_c;
			hit_q  <= hit_c;
			ev_q   <= (kind_c == K_EVICT);
			case (kind_c)
				K_HIT_NEW, K_HIT: f_q <= map_dout_q;
				K_FILL:           f_q <= fused_q[FW-1:0];
				default:          f_q <= oldest_q[FW-1:0];
			endcase
		end
		if (cmd.vic) vic_q <= own_dout_q;
	end

	// block map: sweep clear after reset, one write and one read port
	always_ff @(posedge clk) begin
		if (cmd.clr) map_mem[clr_q] <= '0;
		else if (cmd.push2 && kind_q inside {K_FILL, K_EVICT}) map_mem[bn_q] <= f_q;
		if (cmd.map_rd) map_dout_q <= map_mem[bn_q];
	end

	// frame owners
	logic [FW-1:0] own_ra;
	assign own_ra = cmd.decide ? oldest_q[FW-1:0] : map_dout_q;
	always_ff @(posedge clk) begin
		if (cmd.push2 && kind_q inside {K_FILL, K_EVICT}) own_mem[f_q] <= bn_q;
		if (cmd.own_rd || cmd.decide) own_dout_q <= own_mem[own_ra];
	end

	// recency links
	logic           old_we, new_we;
	logic [FW-1:0]  old_wa, new_wa;
	logic [LKW-1:0] old_wd, new_wd;
	always_comb begin
		old_we = 1'b0;
		old_wa = f_q;
		old_wd = newest_q;
		new_we = 1'b0;
		new_wa = f_q;
		new_wd = NONE;
		if (cmd.unlink) begin
			old_we = (new_dout_q != NONE);
			old_wa = new_dout_q[FW-1:0];
			old_wd = old_dout_q;
			new_we = (old_dout_q != NONE);
			new_wa = old_dout_q[FW-1:0];
			new_wd = new_dout_q;
		end else if (cmd.push1) begin
			old_we = 1'b1;
			new_we = (newest_q != NONE);
			new_wa = newest_q[FW-1:0];
			new_wd = LKW'(f_q);
		end else if (cmd.push2) begin
			new_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (old_we) older_mem[old_wa] <= old_wd;
		if (cmd.lnk_rd) old_dout_q <= older_mem[f_q];
	end

	always_ff @(posedge clk) begin
		if (new_we) newer_mem[new_wa] <= new_wd;
		if (cmd.lnk_rd) new_dout_q <= newer_mem[f_q];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [TW+BN_OUT_W-1:0]    bn_ext, vic_ext;
	logic [FW+FRAME_OUT_W-1:0] f_ext;
	assign bn_ext  = {{BN_OUT_W{1'b0}}, bn_q};
	assign vic_ext = {{BN_OUT_W{1'b0}}, vic_q};
	assign f_ext   = {{FRAME_OUT_W{1'b0}}, f_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.hit          <= hit_q;
			res.block_number <= bn_ext[BN_OUT_W-1:0];
			res.frame        <= f_ext[FRAME_OUT_W-1:0];
			res.evicted      <= ev_q;
			res.victim_block <= vic_ext[BN_OUT_W-1:0];
			res.offset_x     <= off_q[0];
			res.offset_y     <= off_q[1];
			res.offset_z     <= off_q[2];
			res.offset_t     <= off_q[3];
			res.offset_v     <= off_q[4];
		end
	end
	assign res.valid = out_valid_q;

	assign sts.clr_last = (clr_q == TW'(TABLE_ENTRIES - 1));
	assign sts.is_flush = op_q;
	assign sts.div_done = div_done;
	assign sts.last_dim = (d_q == nd_eff - DIMS_W'(1));
	assign sts.kind     = kind_c;
	assign sts.out_busy = out_valid_q && !res.ready;
endmodule

/* design/bvc_ctrl.sv */
// Controller state machine sequencing numbering, lookup and recency update.
`timescale 1ns / 1ps
module bvc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bvc_pkg::sts_t sts,
	output bvc_pkg::cmd_t cmd
);
	import bvc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_START;
			S_START:  state_d = sts.is_flush ? S_DONE : S_DIVQ;
			S_DIVQ:   if (sts.div_done) state_d = S_MUL;
			S_MUL:    state_d = S_MOD;
			S_MOD:    state_d = sts.last_dim ? S_MAPRD : S_START;
			S_MAPRD:  state_d = S_OWNRD;
			S_OWNRD:  state_d = S_DECIDE;
			S_DECIDE: begin
				case (sts.kind)
					K_HIT_NEW: state_d = S_DONE;
					K_HIT:     state_d = S_LNKRD;
					K_FILL:    state_d = S_PUSH1;
					default:   state_d = S_VIC;
				endcase
			end
			S_VIC:    state_d = S_LNKRD;
			S_LNKRD:  state_d = S_UNLINK;
			S_UNLINK: state_d = S_PUSH1;
			S_PUSH1:  state_d = S_PUSH2;
			S_PUSH2:  state_d = S_DONE;
			S_DONE:   if (!sts.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR:  cmd.clr = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_START: begin
				cmd.flush     = sts.is_flush;
				cmd.div_coord = !sts.is_flush;
			end
			S_DIVQ:   cmd.off_wr = sts.div_done;
			S_MUL:    cmd.mul = 1'b1;
			S_MOD: begin
				cmd.mod_wr   = 1'b1;
				cmd.dim_next = !sts.last_dim;
			end
			S_MAPRD:  cmd.map_rd = 1'b1;
			S_OWNRD:  cmd.own_rd = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_VIC:    cmd.vic = 1'b1;
			S_LNKRD:  cmd.lnk_rd = 1'b1;
			S_UNLINK: cmd.unlink = 1'b1;
			S_PUSH1:  cmd.push1 = 1'b1;
			S_PUSH2:  cmd.push2 = 1'b1;
			S_DONE:   cmd.out_load = !sts.out_busy;
			default:  cmd = '0;
		endcase
	end
endmodule

/* design/blocked_volume_lru_cache.sv */
// Top level of the blocked volume LRU block cache.
//
//  channel | dir | handshake   | carries
//  --------+-----+-------------+-----------------------------------------------
//  acc     | in  | valid/ready | op, coord_x..coord_v
//  res     | out | valid/ready | hit, block_number, frame, evicted,
//          |     |             | victim_block, offset_x..offset_v
//  cfg     | in  | valid/ready | index (register), data; ready is always high
//
// One item at a time. For an access each used dimension runs the bit-serial
// coordinate by block edge divider, then a multiply-add that wraps at
// TABLE_ENTRIES (a power of two). A fill skips the victim read and the unlinking,
// and a hit of the newest frame skips the whole recency update. A flush skips
// the numbering and the lookup.
// Reset starts a clearing pass over every block map entry, with
// acc.ready low; cfg writes are still taken.
// A result waits in the output register; the next item is accepted meanwhile
// and stalls only at its end if the previous result has not been taken.
`timescale 1ns / 1ps
module blocked_volume_lru_cache #(
	parameter int MAX_FRAMES    = 64,
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	bvc_acc_if.sink   acc,
	bvc_res_if.source res,
	bvc_cfg_if.sink   cfg
);
	import bvc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// controller only sees handshake status and datapath flags
	bvc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(acc.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	assign acc.ready = in_ready;

	// datapath holds config, numbering, map and LRU list; map entry is trusted
	// only when its frame is in use and that frame's owner matches the block
	bvc_dp #(
		.MAX_FRAMES   (MAX_FRAMES),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.acc   (acc),
		.res   (res),
		.cfg   (cfg)
	);
endmodule

/* design/bvc_chk.sv */
// Port checker for the blocked volume LRU cache, bound to the top level.
`timescale 1ns / 1ps
module bvc_chk (
	input logic clk,
	input logic arst_n,
	input logic acc_valid,
	input logic acc_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_hit,
	input logic res_evicted,
	input logic [11:0] res_victim
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && acc_ready |=> !acc_ready)
		else $error("second item taken while one is at work");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_evicted |-> !res_hit)
		else $error("eviction reported on a hit");

	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_evicted |-> res_victim == 12'd0)
		else $error("victim block set without eviction");
endmodule

bind blocked_volume_lru_cache bvc_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.acc_valid  (acc.valid),
	.acc_ready  (acc.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_hit    (res.hit),
	.res_evicted(res.evicted),
	.res_victim (res.victim_block)
);
